// ===== rtl/core/cpid_pkg.sv =====
// shared types and constants for the clamped pid block
`default_nettype none

package cpid_pkg;

    localparam int GAIN_W     = 12;
    localparam int BYTE_W     = 8;
    localparam int BAND_W     = 12;
    localparam int MODE_W     = 2;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // result mode codes
    localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ON  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PID = 2'd2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_KP     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KI     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KD     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PRESET = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_UPPER  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LOWER  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_BAND   = 3'd6;

    // reset values
    localparam logic [GAIN_W-1:0] KP_RST     = 12'd256;
    localparam logic [GAIN_W-1:0] KI_RST     = 12'd26;
    localparam logic [GAIN_W-1:0] KD_RST     = 12'd51;
    localparam logic [BYTE_W-1:0] PRESET_RST = 8'd20;
    localparam logic [BYTE_W-1:0] UPPER_RST  = 8'd255;
    localparam logic [BYTE_W-1:0] LOWER_RST  = 8'd0;
    localparam logic [BAND_W-1:0] BAND_RST   = 12'd300;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
        logic [BYTE_W-1:0] preset;
        logic [BYTE_W-1:0] drive_max;
        logic [BYTE_W-1:0] drive_min;
        logic [BAND_W-1:0] band;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/core/cpid_if.sv =====
// sample and result channel interfaces
`default_nettype none

interface cpid_in_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] setpoint;
    logic [SAMPLE_BITS-1:0] measured;

    modport source (output valid, output setpoint, output measured, input ready);
    modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

interface cpid_out_if;
    logic                          valid;
    logic                          ready;
    logic [cpid_pkg::BYTE_W-1:0]   drive;
    logic [cpid_pkg::MODE_W-1:0]   mode;

    modport source (output valid, output drive, output mode, input ready);
    modport sink   (input valid, input drive, input mode, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/clamped_pid_with_band_override.sv =====
// top level of the clamped pid controller with band override
//
//  channel   dir   handshake          payload
//  i_in      in    valid / ready      setpoint, measured
//  o_out     out   valid / ready      drive, mode
//  apb       in    psel, penable      paddr, pwdata, pwrite, prdata (pready tied high)
//
// one sample per cycle sustained while the result is not stalled; each sample loads the
// input register, then the result register once that is free or being emptied
// the pid math is a single combinational pass between the input and result registers,
// and the integral and previous error update at the edge that loads the result
// synchronous active-low reset clears valid bits and pid state, resets the registers
// a stalled result drops i_in.ready only once the input register is also full
`default_nettype none

module clamped_pid_with_band_override #(
    parameter int SAMPLE_BITS    = 12,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    cpid_in_if.sink                                  i_in,
    cpid_out_if.source                               o_out,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [cpid_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [cpid_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [cpid_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready
);

    localparam int LIM_W = GAIN_FRAC_BITS + 9;

    cpid_pkg::t_cfg cfg;

    // input register
    logic                          r_in_valid;
    logic [SAMPLE_BITS-1:0]        r_setpoint;
    logic [SAMPLE_BITS-1:0]        r_measured;

    // result register
    logic                          r_out_valid;
    logic [cpid_pkg::BYTE_W-1:0]   r_drive;
    logic [cpid_pkg::MODE_W-1:0]   r_mode;

    // controller state
    logic signed [LIM_W-1:0]       r_integral;
    logic signed [SAMPLE_BITS:0]   r_prev_err;

    logic signed [LIM_W-1:0]       n_integral;
    logic signed [SAMPLE_BITS:0]   n_prev_err;
    logic [cpid_pkg::BYTE_W-1:0]   n_drive;
    logic [cpid_pkg::MODE_W-1:0]   n_mode;

    logic                          in_take;
    logic                          advance;

    assign pready = 1'b1;

    cpid_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    cpid_calc #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_calc (
        .i_cfg      (cfg),
        .i_setpoint (r_setpoint),
        .i_measured (r_measured),
        .i_integral (r_integral),
        .i_prev_err (r_prev_err),
        .o_integral (n_integral),
        .o_prev_err (n_prev_err),
        .o_drive    (n_drive),
        .o_mode     (n_mode)
    );

    // the sample moves on when the result register is free or being emptied
    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign in_take     = i_in.valid && i_in.ready;

    assign o_out.valid = r_out_valid;
    assign o_out.drive = r_drive;
    assign o_out.mode  = r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_setpoint <= i_in.setpoint;
            r_measured <= i_in.measured;
        end
    end

    // result valid and pid state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_integral  <= '0;
            r_prev_err  <= '0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
            r_integral  <= n_integral;
            r_prev_err  <= n_prev_err;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_drive <= n_drive;
            r_mode  <= n_mode;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cpid_regs.sv =====
// apb configuration register file
`default_nettype none

module cpid_regs (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [cpid_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [cpid_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [cpid_pkg::APB_DATA_W-1:0]     prdata,
    output cpid_pkg::t_cfg                           o_cfg
);

    cpid_pkg::t_cfg                      r_cfg;
    logic [cpid_pkg::REG_IDX_W-1:0]      idx;
    logic                                wr_en;

    assign idx   = paddr[cpid_pkg::APB_ADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp        <= cpid_pkg::KP_RST;
            r_cfg.ki        <= cpid_pkg::KI_RST;
            r_cfg.kd        <= cpid_pkg::KD_RST;
            r_cfg.preset    <= cpid_pkg::PRESET_RST;
            r_cfg.drive_max <= cpid_pkg::UPPER_RST;
            r_cfg.drive_min <= cpid_pkg::LOWER_RST;
            r_cfg.band      <= cpid_pkg::BAND_RST;
        end else if (wr_en) begin
            case (idx)
                cpid_pkg::REG_KP:     r_cfg.kp        <= pwdata[cpid_pkg::GAIN_W-1:0];
                cpid_pkg::REG_KI:     r_cfg.ki        <= pwdata[cpid_pkg::GAIN_W-1:0];
                cpid_pkg::REG_KD:     r_cfg.kd        <= pwdata[cpid_pkg::GAIN_W-1:0];
                cpid_pkg::REG_PRESET: r_cfg.preset    <= pwdata[cpid_pkg::BYTE_W-1:0];
                cpid_pkg::REG_UPPER:  r_cfg.drive_max <= pwdata[cpid_pkg::BYTE_W-1:0];
                cpid_pkg::REG_LOWER:  r_cfg.drive_min <= pwdata[cpid_pkg::BYTE_W-1:0];
                cpid_pkg::REG_BAND:   r_cfg.band      <= pwdata[cpid_pkg::BAND_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            cpid_pkg::REG_KP:     prdata = cpid_pkg::APB_DATA_W'(r_cfg.kp);
            cpid_pkg::REG_KI:     prdata = cpid_pkg::APB_DATA_W'(r_cfg.ki);
            cpid_pkg::REG_KD:     prdata = cpid_pkg::APB_DATA_W'(r_cfg.kd);
            cpid_pkg::REG_PRESET: prdata = cpid_pkg::APB_DATA_W'(r_cfg.preset);
            cpid_pkg::REG_UPPER:  prdata = cpid_pkg::APB_DATA_W'(r_cfg.drive_max);
            cpid_pkg::REG_LOWER:  prdata = cpid_pkg::APB_DATA_W'(r_cfg.drive_min);
            cpid_pkg::REG_BAND:   prdata = cpid_pkg::APB_DATA_W'(r_cfg.band);
            default:              prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/cpid_calc.sv =====
// single-pass pid datapath: band check, gain products, term clamps, output
`default_nettype none

module cpid_calc #(
    parameter int SAMPLE_BITS    = 12,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  wire cpid_pkg::t_cfg                  i_cfg,
    input  wire logic        [SAMPLE_BITS-1:0]   i_setpoint,
    input  wire logic        [SAMPLE_BITS-1:0]   i_measured,
    input  wire logic signed [GAIN_FRAC_BITS+8:0] i_integral,
    input  wire logic signed [SAMPLE_BITS:0]     i_prev_err,
    output logic signed      [GAIN_FRAC_BITS+8:0] o_integral,
    output logic signed      [SAMPLE_BITS:0]     o_prev_err,
    output logic             [cpid_pkg::BYTE_W-1:0] o_drive,
    output logic             [cpid_pkg::MODE_W-1:0] o_mode
);

    localparam int LIM_W  = GAIN_FRAC_BITS + 9;
    localparam int PROD_W = SAMPLE_BITS + cpid_pkg::GAIN_W + 3;
    localparam int W      = ((PROD_W > LIM_W + 2) ? PROD_W : LIM_W + 2) + 1;

    function automatic logic signed [W-1:0] clamp_w(
        input logic signed [W-1:0] v,
        input logic signed [W-1:0] lo,
        input logic signed [W-1:0] hi
    );
        logic signed [W-1:0] t;
        t = v;
        if (t > hi) t = hi;
        if (t < lo) t = lo;
        return t;
    endfunction

    logic signed [SAMPLE_BITS:0]   err;
    logic signed [SAMPLE_BITS+1:0] err_diff;
    logic signed [PROD_W-2:0]      p_prod;
    logic signed [PROD_W-2:0]      i_prod;
    logic signed [PROD_W-1:0]      d_prod;
    logic signed [W-1:0]           err_w;
    logic signed [W-1:0]           band_w;
    logic signed [W-1:0]           hi_w;
    logic signed [W-1:0]           lo_w;
    logic signed [W-1:0]           p_term;
    logic signed [W-1:0]           i_acc;
    logic signed [W-1:0]           i_term;
    logic signed [W-1:0]           d_term;
    logic signed [W-1:0]           sum_c;
    logic signed [W-1:0]           whole;
    logic                          force_off;
    logic                          force_on;
    logic                          ki_on;
    logic                          kd_on;

    assign err      = signed'({1'b0, i_setpoint}) - signed'({1'b0, i_measured});
    assign err_diff = (SAMPLE_BITS+2)'(err) - (SAMPLE_BITS+2)'(i_prev_err);

    assign p_prod = (PROD_W-1)'(err) * (PROD_W-1)'(signed'({1'b0, i_cfg.kp}));
    assign i_prod = (PROD_W-1)'(err) * (PROD_W-1)'(signed'({1'b0, i_cfg.ki}));
    assign d_prod = PROD_W'(err_diff) * PROD_W'(signed'({1'b0, i_cfg.kd}));

    assign err_w  = W'(err);
    assign band_w = signed'(W'(i_cfg.band));
    assign force_off = err_w < -band_w;
    assign force_on  = err_w > band_w;

    // term limits, shifted by the preset and scaled to the gain fraction
    assign hi_w = (signed'(W'(i_cfg.drive_max)) - signed'(W'(i_cfg.preset)))
                  <<< GAIN_FRAC_BITS;
    assign lo_w = (signed'(W'(i_cfg.drive_min)) - signed'(W'(i_cfg.preset)))
                  <<< GAIN_FRAC_BITS;

    assign ki_on = i_cfg.ki != '0;
    assign kd_on = i_cfg.kd != '0;

    assign p_term = clamp_w(W'(p_prod), lo_w, hi_w);
    assign i_acc  = W'(i_integral) + W'(i_prod);
    assign i_term = ki_on ? clamp_w(i_acc, lo_w, hi_w) : '0;
    assign d_term = kd_on ? clamp_w(W'(d_prod), lo_w, hi_w) : '0;
    assign sum_c  = clamp_w(p_term + i_term + d_term, lo_w, hi_w);
    assign whole  = sum_c >>> GAIN_FRAC_BITS;

    always_comb begin
        if (force_off) begin
            o_drive    = i_cfg.drive_min;
            o_mode     = cpid_pkg::MODE_OFF;
            o_integral = i_integral;
            o_prev_err = i_prev_err;
        end else if (force_on) begin
            o_drive    = i_cfg.drive_max;
            o_mode     = cpid_pkg::MODE_ON;
            o_integral = i_integral;
            o_prev_err = i_prev_err;
        end else begin
            o_drive    = whole[cpid_pkg::BYTE_W-1:0] + i_cfg.preset;
            o_mode     = cpid_pkg::MODE_PID;
            o_integral = i_term[LIM_W-1:0];
            o_prev_err = kd_on ? err : i_prev_err;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cpid_chk.sv =====
// port-level checker for the clamped pid block, bound to the top level
`default_nettype none

module cpid_chk (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              i_in_ready,
    input wire logic                              i_out_valid,
    input wire logic                              i_out_ready,
    input wire logic [cpid_pkg::BYTE_W-1:0]       i_out_drive,
    input wire logic [cpid_pkg::MODE_W-1:0]       i_out_mode
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_drive) && $stable(i_out_mode))
        else $error("result payload changed while stalled");

    // input back-pressure only when a result is waiting and stalled
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input blocked without a stalled result");

    // a new result follows an input transaction that was loaded into the input register
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result appeared without a matching input transaction");

endmodule

bind clamped_pid_with_band_override cpid_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_drive (o_out.drive),
    .i_out_mode  (o_out.mode)
);

`default_nettype wire
